### hw/rtl/mexp_pkg.sv
// Shared constants for the modular exponentiation block.
// No dependencies.
`default_nettype none
package mexp_pkg;
  localparam int FIELD_W = 64;
  localparam int IN_W    = 2 * FIELD_W;

  typedef logic [FIELD_W-1:0] field_t;
endpackage
`default_nettype wire

### hw/rtl/mexp_cell.sv
// Serial modular multiplier cell: r = a * b mod m, one add-and-reduce per cycle.
// Multiplier bits MSB first, a doubling then a conditional add for each. Depends on nothing.
`default_nettype none
module mexp_cell #(
  parameter int WIDTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] a_in,
  input  wire logic [WIDTH-1:0] b_in,
  input  wire logic [WIDTH-1:0] m_in,
  output logic                  done,
  output logic [WIDTH-1:0]      r
);
  localparam int IDX_W = $clog2(WIDTH);

  logic             busy;
  logic             phase;
  logic [IDX_W-1:0] idx;
  logic [WIDTH-1:0] a;
  logic [WIDTH-1:0] b;
  logic [WIDTH-1:0] m;
  logic [WIDTH-1:0] addend;
  logic [WIDTH:0]   sum;
  logic [WIDTH:0]   red;
  logic [WIDTH-1:0] r_next;

  always_comb begin
    addend = phase ? a : r;
    sum    = {1'b0, r} + {1'b0, addend};
    red    = (sum >= {1'b0, m}) ? (sum - {1'b0, m}) : sum;
    r_next = (phase && !b[idx]) ? r : red[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
      idx   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        idx   <= IDX_W'(WIDTH - 1);
      end else if (busy) begin
        phase <= !phase;
        if (phase) begin
          if (idx == '0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            idx <= idx - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a <= a_in;
      b <= b_in;
      m <= m_in;
      r <= '0;
    end else if (busy) begin
      r <= r_next;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/modular_exponentiation.sv
// Right-to-left square-and-multiply, base^exponent mod modulus, two multiplier cells.
// Steps from input transfer to result valid: one base reduction and WIDTH steps,
// each a square and a product run side by side; a zero modulus skips both.
// Input is taken only when idle, after the previous result is registered;
// a held result does not block the next input.
// Reset: synchronous, clears control and sets modulus to 1.
`default_nettype none
module modular_exponentiation
  import mexp_pkg::*;
#(
  parameter int WIDTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [FIELD_W-1:0] cfg_wdata,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [IN_W-1:0]   s_axis_tdata,   // base [63:0], exponent [127:64]
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [FIELD_W-1:0]     m_axis_tdata    // power [63:0]
);
  localparam int CNT_W = $clog2(WIDTH);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RED  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]       state;
  logic [FIELD_W-1:0] modulus;
  logic [WIDTH-1:0] m;
  logic [WIDTH-1:0] base;
  logic [WIDTH-1:0] e;
  logic [WIDTH-1:0] sq;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] one_m;
  logic [CNT_W-1:0] cnt;
  logic             go;
  logic [WIDTH-1:0] a0;
  logic [WIDTH-1:0] b0;
  logic             done0;
  logic             done1;
  logic [WIDTH-1:0] r0;
  logic [WIDTH-1:0] r1;
  logic [WIDTH-1:0] mod_w;
  logic             s_xfer;

  assign mod_w         = modulus[WIDTH-1:0];
  assign s_axis_tready = (state == ST_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign one_m         = {{(WIDTH-1){1'b0}}, (m != {{(WIDTH-1){1'b0}}, 1'b1})};
  assign a0            = (state == ST_RED) ? one_m : sq;
  assign b0            = (state == ST_RED) ? base : sq;

  mexp_cell #(.WIDTH(WIDTH)) u_cell_sq (
    .clk(clk), .rst(rst), .start(go), .a_in(a0), .b_in(b0), .m_in(m),
    .done(done0), .r(r0)
  );

  mexp_cell #(.WIDTH(WIDTH)) u_cell_acc (
    .clk(clk), .rst(rst), .start(go), .a_in(acc), .b_in(sq), .m_in(m),
    .done(done1), .r(r1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus       <= FIELD_W'(1);
      state         <= ST_IDLE;
      go            <= 1'b0;
      m_axis_tvalid <= 1'b0;
      cnt           <= '0;
    end else begin
      go <= 1'b0;
      if (cfg_we) begin
        modulus <= cfg_wdata;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_xfer) begin
            cnt <= '0;
            if (mod_w == '0) begin
              state <= ST_FIN;
            end else begin
              state <= ST_RED;
              go    <= 1'b1;
            end
          end
        end
        ST_RED: begin
          if (done0) begin
            state <= ST_MUL;
            go    <= 1'b1;
          end
        end
        ST_MUL: begin
          if (done0 && done1) begin
            if (cnt == CNT_W'(WIDTH - 1)) begin
              state <= ST_FIN;
            end else begin
              cnt <= cnt + 1'b1;
              go  <= 1'b1;
            end
          end
        end
        ST_FIN: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_xfer) begin
      m    <= mod_w;
      base <= s_axis_tdata[WIDTH-1:0];
      e    <= s_axis_tdata[FIELD_W+WIDTH-1:FIELD_W];
      acc  <= '0;
    end else if (state == ST_RED && done0) begin
      sq  <= r0;
      acc <= one_m;
    end else if (state == ST_MUL && done0 && done1) begin
      sq <= r0;
      if (e[0]) begin
        acc <= r1;
      end
      e <= e >> 1;
    end
    if (state == ST_FIN && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= FIELD_W'(acc);
    end
  end
endmodule
`default_nettype wire

### hw/rtl/mexp_checker.sv
// Port-level checks for the modular exponentiation block, bound to the top level.
// Depends on mexp_pkg.
`default_nettype none
module mexp_props
  import mexp_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               s_axis_tvalid,
  input wire logic               s_axis_tready,
  input wire logic               m_axis_tvalid,
  input wire logic               m_axis_tready,
  input wire logic [FIELD_W-1:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_lat: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("result too early");
endmodule

bind modular_exponentiation mexp_props u_mexp_props (
  .clk(clk), .rst(rst),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

### sim/mexp_checker.sv
// Checker for modular_exponentiation: watches both stream channels and the
// modulus write port, predicts each power and compares it. Depends on mexp_pkg.
module mexp_checker
  import mexp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [FIELD_W-1:0] cfg_wdata,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [IN_W-1:0]    s_axis_tdata,
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [FIELD_W-1:0] m_axis_tdata,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  field_t modulus;
  field_t powers_due[$];

  function automatic field_t add_mod(field_t a, field_t b, field_t m);
    logic [FIELD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[FIELD_W-1:0];
  endfunction

  function automatic field_t mul_mod(field_t a, field_t b, field_t m);
    field_t r;
    r = '0;
    for (int i = FIELD_W - 1; i >= 0; i--) begin
      r = add_mod(r, r, m);
      if (b[i]) r = add_mod(r, a, m);
    end
    return r;
  endfunction

  function automatic field_t predict_power(field_t b, field_t e, field_t m);
    field_t acc, sq;
    if (m == '0) return '0;
    sq = b % m;
    acc = (m == 1) ? '0 : 1;
    for (int i = 0; i < FIELD_W; i++) begin
      if (e[i]) acc = mul_mod(acc, sq, m);
      sq = mul_mod(sq, sq, m);
    end
    return acc;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    errors++;
  endtask

  assign pending = powers_due.size();

  always @(posedge clk) begin
    field_t want;
    if (rst) begin
      modulus <= 1;
      errors = 0;
      powers_due.delete();
    end else begin
      if (cfg_we) modulus <= cfg_wdata;
      if (s_axis_tvalid && s_axis_tready)
        powers_due.push_back(predict_power(s_axis_tdata[63:0], s_axis_tdata[127:64],
                                           modulus));
      if (m_axis_tvalid && m_axis_tready) begin
        if (powers_due.size() == 0) begin
          report_mismatch($sformatf("unexpected power %h", m_axis_tdata));
        end else begin
          want = powers_due.pop_front();
          if (m_axis_tdata !== want)
            report_mismatch($sformatf("power %h, want %h", m_axis_tdata, want));
        end
      end
    end
  end
endmodule

### sim/tb.sv
// Testbench top for modular_exponentiation: drives modulus writes and
// base/exponent transfers with random idling. Depends on mexp_pkg and mexp_checker.
module tb;
  import mexp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_we = 0;
  logic [FIELD_W-1:0] cfg_wdata = '0;
  logic               s_axis_tvalid = 0;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 0;
  logic [FIELD_W-1:0] m_axis_tdata;
  int                 errors, pending;
  int                 send_idle_pct = 0, recv_stall_pct = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  modular_exponentiation #(.WIDTH(64)) DUT (.*);
  mexp_checker u_checker (.*);

  always @(posedge clk)
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic send_item(field_t b, field_t e);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {e, b};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_modulus(field_t m);
    drain();
    cfg_we <= 1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic field_t rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic field_t rand_modulus();
    case ($urandom_range(3))
      0: return 64'(2 + $urandom_range(1000));
      1: return rand64() | 64'h8000_0000_0000_0000;
      2: return {32'h0, $urandom} | 1;
      default: return rand64() | 1;
    endcase
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // reset modulus of one
    send_item(64'd5, 64'd3);
    send_item('1, '0);
    set_modulus('1);
    send_item('0, '0);
    send_item('0, 64'd1);
    send_item('1, '1);
    send_item('1, 64'd2);
    send_item(64'd2, '1);
    send_item(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_item(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    set_modulus(64'd1);
    send_item(64'd7, 64'd0);
    send_item('1, '1);
    set_modulus(64'hffff_ffff_ffff_ffc5);
    send_item(64'hffff_ffff_ffff_ffc4, 64'd2);
    send_item(64'hffff_ffff_ffff_ffc5, 64'd9);
    send_item(64'd3, 64'hffff_ffff_ffff_ffc4);
    send_item('1, 64'd1);
    set_modulus(64'd2);
    send_item(64'd3, '1);
    send_item(64'd4, 64'd5);
    set_modulus(64'd13);
    send_item(64'd100, 64'd0);
    send_item(64'd12, 64'd12);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 37 : 76) : 0;
      recv_stall_pct = (ph == 2) ? 76 : ((ph == 3) ? 37 : 0);
      set_modulus(rand_modulus());
      for (int i = 0; i < 20; i++) begin
        if (i == 10) set_modulus(rand_modulus());
        send_item(rand64(), ($urandom_range(3) == 0) ? 64'($urandom_range(70)) : rand64());
      end
    end
    drain();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("modular_exponentiation verification clean");
    else
      $display("modular_exponentiation verification failed");
    $finish;
  end

  initial begin
    #100ms;
    $display("modular_exponentiation verification failed");
    $finish;
  end
endmodule
